>>> rtl/core/dep_pkg.sv
// dep_pkg: event codes, constants and shared types of the dual encoder
// position and period core; no dependencies
package dep_pkg;

   localparam logic [1:0] EVT_OVERFLOW = 2'd0;
   localparam logic [1:0] EVT_LEFT     = 2'd1;
   localparam logic [1:0] EVT_RIGHT    = 2'd2;

   localparam logic [15:0] STOPPED_PERIOD = 16'hFFFF;
   localparam logic [7:0]  COUNT_MAX      = 8'd255;
   localparam logic [7:0]  STALL_RESET    = 8'd2;

   // per channel update strobe from the core to a channel tracker
   typedef struct packed {
      logic        hit;
      logic        tick;
      logic        forward;
      logic [15:0] capture;
   } chan_ctl_type;

   // state after the update, as the result shows it
   typedef struct packed {
      logic signed [31:0] position;
      logic [15:0]        period;
   } chan_view_type;

endpackage

>>> rtl/core/dep_if.sv
// dep_if: valid/ready channel interfaces for event requests and results
// depends on nothing
interface dep_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] capture_value;
   logic        forward;

   modport source (output valid, output req_type, output capture_value,
                   output forward, input ready);
   modport sink (input valid, input req_type, input capture_value,
                 input forward, output ready);
endinterface

interface dep_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_position;
   logic signed [31:0] right_position;
   logic [15:0]        left_period;
   logic [15:0]        right_period;

   modport source (output valid, output left_position, output right_position,
                   output left_period, output right_period, input ready);
   modport sink (input valid, input left_position, input right_position,
                 input left_period, input right_period, output ready);
endinterface

>>> rtl/core/dual_encoder_position_period_core.sv
// dual_encoder_position_period_core: two-channel encoder position and period tracker
// depends on dep_pkg, dep_if (dep_req_if, dep_rsp_if) and dep_channel
//
//   channel  direction  handshake         payload
//   req_if   in         valid/ready       req_type, capture_value, forward
//   rsp_if   out        valid/ready       left/right position, left/right period
//   csr      in         write enable      stall_overflows (8 bits)
//
// one event per cycle sustained while rsp_if.ready holds; each event passes the input register
// and then the result register, from which it is offered and can transfer out at the following edge
// reset clears all channel state, both stage valids, and loads stall_overflows with 2
// a stalled result holds in the result register while one more event waits in
// the input register; req_if.ready drops only when both are full
module dual_encoder_position_period_core (
   input  logic        clock,
   input  logic        reset,
   dep_req_if.sink     req_if,
   dep_rsp_if.source   rsp_if,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_type_ff;
   logic [15:0] in_capture_ff;
   logic        in_forward_ff;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  stall_ff;
   logic        advance;
   logic        req_take;

   dep_pkg::chan_ctl_type  left_ctl, right_ctl;
   dep_pkg::chan_view_type left_view, right_view;

   logic signed [31:0] left_position_ff, right_position_ff;
   logic [15:0]        left_period_ff, right_period_ff;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      left_ctl.hit      = advance && (in_type_ff == dep_pkg::EVT_LEFT);
      left_ctl.tick     = advance && (in_type_ff == dep_pkg::EVT_OVERFLOW);
      left_ctl.forward  = in_forward_ff;
      left_ctl.capture  = in_capture_ff;
      right_ctl.hit     = advance && (in_type_ff == dep_pkg::EVT_RIGHT);
      right_ctl.tick    = left_ctl.tick;
      right_ctl.forward = in_forward_ff;
      right_ctl.capture = in_capture_ff;
   end

   dep_channel u_left (
      .clock           (clock),
      .reset           (reset),
      .ctl             (left_ctl),
      .stall_overflows (stall_ff),
      .view            (left_view)
   );

   dep_channel u_right (
      .clock           (clock),
      .reset           (reset),
      .ctl             (right_ctl),
      .stall_overflows (stall_ff),
      .view            (right_view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         stall_ff     <= dep_pkg::STALL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_en) begin
            stall_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff    <= req_if.req_type;
         in_capture_ff <= req_if.capture_value;
         in_forward_ff <= req_if.forward;
      end
      if (advance) begin
         left_position_ff  <= left_view.position;
         right_position_ff <= right_view.position;
         left_period_ff    <= left_view.period;
         right_period_ff   <= right_view.period;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.left_position  = left_position_ff;
   assign rsp_if.right_position = right_position_ff;
   assign rsp_if.left_period    = left_period_ff;
   assign rsp_if.right_period   = right_period_ff;

   a_advance_fills_output : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_if.valid)
      else $error("result register not loaded after a transfer");

   a_zero_threshold_stops : assert property (@(posedge clock) disable iff (reset)
      advance && (in_type_ff == dep_pkg::EVT_OVERFLOW) && (stall_ff == 8'd0)
      |=> (rsp_if.left_period == dep_pkg::STOPPED_PERIOD)
          && (rsp_if.right_period == dep_pkg::STOPPED_PERIOD))
      else $error("overflow with zero threshold did not stop both channels");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_if.valid && !in_valid_ff && req_if.ready)
      else $error("pipeline not empty after reset");

endmodule

>>> rtl/core/dep_channel.sv
// dep_channel: position, period and overflow tracking of one encoder channel
// depends on dep_pkg
module dep_channel (
   input  logic                  clock,
   input  logic                  reset,
   input  dep_pkg::chan_ctl_type ctl,
   input  logic [7:0]            stall_overflows,
   output dep_pkg::chan_view_type view
);

   logic signed [31:0] position_ff, position_in;
   logic [15:0]        last_capture_ff, last_capture_in;
   logic [15:0]        period_ff, period_in;
   logic [7:0]         overflow_ff, overflow_in;

   always_comb begin
      position_in     = position_ff;
      last_capture_in = last_capture_ff;
      period_in       = period_ff;
      overflow_in     = overflow_ff;
      if (ctl.hit) begin
         position_in     = ctl.forward ? position_ff + 32'sd1 : position_ff - 32'sd1;
         period_in       = ctl.capture - last_capture_ff;
         last_capture_in = ctl.capture;
         overflow_in     = 8'd0;
      end else if (ctl.tick) begin
         if (overflow_ff < dep_pkg::COUNT_MAX) begin
            overflow_in = overflow_ff + 8'd1;
         end
         if (overflow_in >= stall_overflows) begin
            period_in = dep_pkg::STOPPED_PERIOD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff     <= '0;
         last_capture_ff <= '0;
         period_ff       <= '0;
         overflow_ff     <= '0;
      end else begin
         position_ff     <= position_in;
         last_capture_ff <= last_capture_in;
         period_ff       <= period_in;
         overflow_ff     <= overflow_in;
      end
   end

   assign view.position = position_in;
   assign view.period   = period_in;

endmodule
